// File: sv/rbpf_pkg.sv
// package of constants, types and microcode for the resonator band-pass filter
package rbpf_pkg;

  // word widths
  localparam int STATE_WIDTH   = 40;
  localparam int SAMPLE_W      = 16;
  localparam int COEF_W        = 24;
  localparam int GAIN_W        = 23;
  localparam int LOG_W         = 3;
  localparam int CFG_W         = 24;
  localparam int CFG_IDX_W     = 2;
  localparam int FRAC_SHIFT    = 22;
  localparam int OUT_SHIFT     = 9;
  localparam int OPND_W        = STATE_WIDTH + 1;
  localparam int HI_W          = OPND_W - FRAC_SHIFT;
  localparam int LO_W          = FRAC_SHIFT + 1;
  localparam int MOP_W         = (HI_W > LO_W) ? HI_W : LO_W;
  localparam int PROD_W        = COEF_W + MOP_W;
  localparam int ACC_W         = STATE_WIDTH + 4;
  localparam int STEP_W        = 4;
  localparam int RAMP_W        = 8;
  localparam int RAMP_MAX      = 1 << ((1 << LOG_W) - 1);
  localparam int RAMP_LOG2_RST = 4;
  localparam int ROUND_HALF    = 1 << (FRAC_SHIFT - 1);
  localparam int OUT_HALF      = 1 << (OUT_SHIFT - 1);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_GAIN = 2'd0,
    REG_TARGET_FB1  = 2'd1,
    REG_TARGET_FB2  = 2'd2,
    REG_RAMP_LOG2   = 2'd3
  } cfg_reg_t;

  // microcode field codes
  typedef enum logic {
    JMP_NONE,
    JMP_NO_PEND
  } jmp_t;

  typedef enum logic [2:0] {
    ACC_NOP,
    ACC_LOAD_X,
    ACC_ADD_LO,
    ACC_ADD_HI,
    ACC_CLR
  } acc_op_t;

  typedef enum logic [1:0] {
    COEF_GAIN,
    COEF_FB1,
    COEF_FB2
  } coef_sel_t;

  typedef enum logic [1:0] {
    OPND_H1,
    OPND_H2,
    OPND_DIFF
  } opnd_sel_t;

  typedef enum logic {
    PART_LO,
    PART_HI
  } part_t;

  // one control word of the program
  typedef struct packed {
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
    logic              arm;
    acc_op_t           acc_op;
    coef_sel_t         coef_sel;
    opnd_sel_t         opnd_sel;
    part_t             part;
    logic              save_w;
    logic              finish;
  } ctl_word_t;

  localparam logic [STEP_W-1:0] STEP_FILTER = 4'd2;

  // program store: arm, w = x + b1*w1 + b2*w2, v = a0*(w - w2), write back
  function automatic ctl_word_t ucode(input logic [STEP_W-1:0] addr);
    ctl_word_t cw;
    cw          = '0;
    cw.jmp      = JMP_NONE;
    cw.target   = STEP_FILTER;
    cw.acc_op   = ACC_NOP;
    cw.coef_sel = COEF_FB1;
    cw.opnd_sel = OPND_H1;
    cw.part     = PART_LO;
    unique case (addr)
      4'd0: begin
        cw.jmp = JMP_NO_PEND;
      end
      4'd1: begin
        cw.arm = 1'b1;
      end
      4'd2: begin
        cw.acc_op = ACC_LOAD_X;
      end
      4'd3: begin
        cw.acc_op = ACC_ADD_LO;
        cw.part   = PART_HI;
      end
      4'd4: begin
        cw.acc_op   = ACC_ADD_HI;
        cw.coef_sel = COEF_FB2;
        cw.opnd_sel = OPND_H2;
      end
      4'd5: begin
        cw.acc_op   = ACC_ADD_LO;
        cw.coef_sel = COEF_FB2;
        cw.opnd_sel = OPND_H2;
        cw.part     = PART_HI;
      end
      4'd6: begin
        cw.acc_op = ACC_ADD_HI;
      end
      4'd7: begin
        cw.save_w = 1'b1;
      end
      4'd8: begin
        cw.acc_op   = ACC_CLR;
        cw.coef_sel = COEF_GAIN;
        cw.opnd_sel = OPND_DIFF;
      end
      4'd9: begin
        cw.acc_op   = ACC_ADD_LO;
        cw.coef_sel = COEF_GAIN;
        cw.opnd_sel = OPND_DIFF;
        cw.part     = PART_HI;
      end
      4'd10: begin
        cw.acc_op = ACC_ADD_HI;
      end
      default: begin
        cw.finish = 1'b1;
      end
    endcase
    return cw;
  endfunction

endpackage

// File: sv/resonator_bandpass_filter_unit.sv
// top level of the resonator band-pass filter: microcoded sequencer and datapath
//
//   port group   direction  beat content          flow control
//   in_*         input      sample_in, Q1.15      in_valid / in_stall
//   out_*        output     sample_out, Q1.15     out_valid / out_stall
//   cfg_*        input      index + data write    cfg_we, no wait
//
// each sample runs the microcode program after its beat, with an arming step added when a ramp
// is armed; the program runs three coefficient products over one shared multiplier,
// each product in two halves; the next beat is taken as soon as the program ends.
// synchronous active-low reset clears history, coefficients and the ramp, and arms a
// ramp to the reset targets for the first sample.
// a result held by out_stall keeps the program on its last step until it is taken.
module resonator_bandpass_filter_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [rbpf_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [rbpf_pkg::SAMPLE_W-1:0] out_sample_out,
  input  logic                                 cfg_we,
  input  logic [rbpf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rbpf_pkg::CFG_W-1:0]           cfg_data
);

  localparam int SW = rbpf_pkg::STATE_WIDTH;
  localparam int CW = rbpf_pkg::COEF_W;

  // configuration registers
  logic [rbpf_pkg::GAIN_W-1:0]          tgt_gain_r, tgt_gain_nxt;
  logic signed [CW-1:0]                 tgt_fb1_r, tgt_fb1_nxt;
  logic signed [CW-1:0]                 tgt_fb2_r, tgt_fb2_nxt;
  logic [rbpf_pkg::LOG_W-1:0]           ramp_log2_r, ramp_log2_nxt;

  // filter and ramp state
  logic signed [SW-1:0]                 hist1_r, hist1_nxt;
  logic signed [SW-1:0]                 hist2_r, hist2_nxt;
  logic signed [CW-1:0]                 cur_gain_r, cur_gain_nxt;
  logic signed [CW-1:0]                 cur_fb1_r, cur_fb1_nxt;
  logic signed [CW-1:0]                 cur_fb2_r, cur_fb2_nxt;
  logic signed [CW-1:0]                 stp_gain_r, stp_gain_nxt;
  logic signed [CW-1:0]                 stp_fb1_r, stp_fb1_nxt;
  logic signed [CW-1:0]                 stp_fb2_r, stp_fb2_nxt;
  logic [rbpf_pkg::RAMP_W-1:0]          ramp_left_r, ramp_left_nxt;
  logic [1:0]                           phase_r, phase_nxt;
  logic                                 pending_r, pending_nxt;

  // sequencer and datapath registers
  logic                                 busy_r, busy_nxt;
  logic [rbpf_pkg::STEP_W-1:0]          step_r, step_nxt;
  logic signed [rbpf_pkg::SAMPLE_W-1:0] x_r, x_nxt;
  logic signed [rbpf_pkg::ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [rbpf_pkg::PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [SW-1:0]                 w_r, w_nxt;
  logic signed [rbpf_pkg::OPND_W-1:0]   diff_r, diff_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic signed [rbpf_pkg::SAMPLE_W-1:0] out_sample_r, out_sample_nxt;

  // combinational helpers
  rbpf_pkg::ctl_word_t                  ctl;
  logic                                 in_beat;
  logic                                 finish_go;
  logic signed [CW-1:0]                 coef;
  logic signed [rbpf_pkg::OPND_W-1:0]   opnd;
  logic signed [rbpf_pkg::MOP_W-1:0]    mop;
  logic signed [SW-1:0]                 w_sat;
  logic signed [rbpf_pkg::ACC_W-1:0]    v_shift;
  logic signed [rbpf_pkg::SAMPLE_W-1:0] y_sat;
  logic [1:0]                           phase_inc;

  // saturate a 25-bit value to 24 bits signed
  function automatic logic signed [CW-1:0] sat_coef(input logic signed [CW:0] v);
    logic signed [CW-1:0] r;
    if (v[CW] != v[CW-1]) begin
      r = v[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // ramp step: (target - current) >>> k, saturated
  function automatic logic signed [CW-1:0] ramp_step(input logic signed [CW:0] tgt,
                                                     input logic signed [CW-1:0] cur,
                                                     input logic [rbpf_pkg::LOG_W-1:0] k);
    logic signed [CW:0] d;
    d = tgt - (CW+1)'(cur);
    return sat_coef(d >>> k);
  endfunction

  assign ctl       = rbpf_pkg::ucode(step_r);
  assign in_stall  = busy_r;
  assign in_beat   = in_valid && !busy_r;
  assign finish_go = busy_r && ctl.finish && !(out_valid_r && out_stall);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // multiplier operand selection, one half of the state word at a time
  always_comb begin
    case (ctl.coef_sel)
      rbpf_pkg::COEF_GAIN: coef = cur_gain_r;
      rbpf_pkg::COEF_FB2:  coef = cur_fb2_r;
      default:             coef = cur_fb1_r;
    endcase
    case (ctl.opnd_sel)
      rbpf_pkg::OPND_H2:   opnd = (rbpf_pkg::OPND_W)'(hist2_r);
      rbpf_pkg::OPND_DIFF: opnd = diff_r;
      default:             opnd = (rbpf_pkg::OPND_W)'(hist1_r);
    endcase
    if (ctl.part == rbpf_pkg::PART_HI) begin
      mop = (rbpf_pkg::MOP_W)'(signed'(opnd[rbpf_pkg::OPND_W-1:rbpf_pkg::FRAC_SHIFT]));
    end else begin
      mop = {{(rbpf_pkg::MOP_W-rbpf_pkg::FRAC_SHIFT){1'b0}},
             opnd[rbpf_pkg::FRAC_SHIFT-1:0]};
    end
  end

  // saturation of w and of the output sample
  always_comb begin
    if (acc_r[rbpf_pkg::ACC_W-1:SW-1] != {(rbpf_pkg::ACC_W-SW+1){acc_r[rbpf_pkg::ACC_W-1]}})
    begin
      w_sat = acc_r[rbpf_pkg::ACC_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      w_sat = acc_r[SW-1:0];
    end
    v_shift = (acc_r + (rbpf_pkg::ACC_W)'(rbpf_pkg::OUT_HALF)) >>> rbpf_pkg::OUT_SHIFT;
    if (v_shift[rbpf_pkg::ACC_W-1:rbpf_pkg::SAMPLE_W-1] !=
        {(rbpf_pkg::ACC_W-rbpf_pkg::SAMPLE_W+1){v_shift[rbpf_pkg::ACC_W-1]}}) begin
      y_sat = v_shift[rbpf_pkg::ACC_W-1] ? {1'b1, {(rbpf_pkg::SAMPLE_W-1){1'b0}}}
                                         : {1'b0, {(rbpf_pkg::SAMPLE_W-1){1'b1}}};
    end else begin
      y_sat = v_shift[rbpf_pkg::SAMPLE_W-1:0];
    end
    phase_inc = phase_r + 2'd1;
  end

  // next-state logic: configuration, sequencer, datapath and write back
  always_comb begin
    tgt_gain_nxt   = tgt_gain_r;
    tgt_fb1_nxt    = tgt_fb1_r;
    tgt_fb2_nxt    = tgt_fb2_r;
    ramp_log2_nxt  = ramp_log2_r;
    hist1_nxt      = hist1_r;
    hist2_nxt      = hist2_r;
    cur_gain_nxt   = cur_gain_r;
    cur_fb1_nxt    = cur_fb1_r;
    cur_fb2_nxt    = cur_fb2_r;
    stp_gain_nxt   = stp_gain_r;
    stp_fb1_nxt    = stp_fb1_r;
    stp_fb2_nxt    = stp_fb2_r;
    ramp_left_nxt  = ramp_left_r;
    phase_nxt      = phase_r;
    pending_nxt    = pending_r;
    busy_nxt       = busy_r;
    step_nxt       = step_r;
    x_nxt          = x_r;
    acc_nxt        = acc_r;
    w_nxt          = w_r;
    diff_nxt       = diff_r;
    out_sample_nxt = out_sample_r;
    out_valid_nxt  = out_valid_r && out_stall;
    prod_nxt       = (rbpf_pkg::PROD_W)'(coef) * (rbpf_pkg::PROD_W)'(mop);

    // input beat starts the program
    if (in_beat) begin
      x_nxt    = in_sample_in;
      busy_nxt = 1'b1;
      step_nxt = '0;
    end

    // step counter with conditional jump
    if (busy_r) begin
      if (ctl.finish) begin
        if (finish_go) begin
          busy_nxt = 1'b0;
          step_nxt = '0;
        end
      end else if (ctl.jmp == rbpf_pkg::JMP_NO_PEND && !pending_r) begin
        step_nxt = ctl.target;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end

    // arm a coefficient ramp
    if (busy_r && ctl.arm) begin
      stp_gain_nxt  = ramp_step((CW+1)'(signed'({2'b00, tgt_gain_r})), cur_gain_r,
                                ramp_log2_r);
      stp_fb1_nxt   = ramp_step((CW+1)'(tgt_fb1_r), cur_fb1_r, ramp_log2_r);
      stp_fb2_nxt   = ramp_step((CW+1)'(tgt_fb2_r), cur_fb2_r, ramp_log2_r);
      ramp_left_nxt = (rbpf_pkg::RAMP_W)'(1) << ramp_log2_r;
      phase_nxt     = 2'd0;
      pending_nxt   = 1'b0;
    end

    // accumulator
    if (busy_r) begin
      case (ctl.acc_op)
        rbpf_pkg::ACC_LOAD_X: acc_nxt = (rbpf_pkg::ACC_W)'(signed'({x_r, 9'b0}));
        rbpf_pkg::ACC_ADD_LO: acc_nxt = acc_r + (rbpf_pkg::ACC_W)'(
                                (prod_r + (rbpf_pkg::PROD_W)'(rbpf_pkg::ROUND_HALF))
                                >>> rbpf_pkg::FRAC_SHIFT);
        rbpf_pkg::ACC_ADD_HI: acc_nxt = acc_r + (rbpf_pkg::ACC_W)'(prod_r);
        rbpf_pkg::ACC_CLR:    acc_nxt = '0;
        default:              acc_nxt = acc_r;
      endcase
    end

    // keep w and w - w2 for the gain product
    if (busy_r && ctl.save_w) begin
      w_nxt    = w_sat;
      diff_nxt = (rbpf_pkg::OPND_W)'(w_sat) - (rbpf_pkg::OPND_W)'(hist2_r);
    end

    // write back: result, history shift and ramp step every third sample
    if (finish_go) begin
      out_sample_nxt = y_sat;
      out_valid_nxt  = 1'b1;
      hist2_nxt      = hist1_r;
      hist1_nxt      = w_r;
      phase_nxt      = phase_inc;
      if (phase_inc == 2'd3) begin
        phase_nxt = 2'd0;
        if (ramp_left_r != '0) begin
          if (ramp_left_r == (rbpf_pkg::RAMP_W)'(1)) begin
            cur_gain_nxt = (CW)'(tgt_gain_r);
            cur_fb1_nxt  = tgt_fb1_r;
            cur_fb2_nxt  = tgt_fb2_r;
          end else begin
            cur_gain_nxt = sat_coef((CW+1)'(cur_gain_r) + (CW+1)'(stp_gain_r));
            cur_fb1_nxt  = sat_coef((CW+1)'(cur_fb1_r) + (CW+1)'(stp_fb1_r));
            cur_fb2_nxt  = sat_coef((CW+1)'(cur_fb2_r) + (CW+1)'(stp_fb2_r));
          end
          ramp_left_nxt = ramp_left_r - 1'b1;
        end
      end
    end

    // configuration writes
    if (cfg_we) begin
      unique case (rbpf_pkg::cfg_reg_t'(cfg_index))
        rbpf_pkg::REG_TARGET_GAIN: begin
          tgt_gain_nxt = cfg_data[rbpf_pkg::GAIN_W-1:0];
          pending_nxt  = 1'b1;
        end
        rbpf_pkg::REG_TARGET_FB1: begin
          tgt_fb1_nxt = signed'(cfg_data);
          pending_nxt = 1'b1;
        end
        rbpf_pkg::REG_TARGET_FB2: begin
          tgt_fb2_nxt = signed'(cfg_data);
          pending_nxt = 1'b1;
        end
        rbpf_pkg::REG_RAMP_LOG2: begin
          ramp_log2_nxt = cfg_data[rbpf_pkg::LOG_W-1:0];
        end
        default: begin
          pending_nxt = pending_r;
        end
      endcase
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    acc_r        <= acc_nxt;
    prod_r       <= prod_nxt;
    w_r          <= w_nxt;
    diff_r       <= diff_nxt;
    out_sample_r <= out_sample_nxt;
    if (!rst_n) begin
      tgt_gain_r  <= '0;
      tgt_fb1_r   <= '0;
      tgt_fb2_r   <= '0;
      ramp_log2_r <= (rbpf_pkg::LOG_W)'(rbpf_pkg::RAMP_LOG2_RST);
      hist1_r     <= '0;
      hist2_r     <= '0;
      cur_gain_r  <= '0;
      cur_fb1_r   <= '0;
      cur_fb2_r   <= '0;
      stp_gain_r  <= '0;
      stp_fb1_r   <= '0;
      stp_fb2_r   <= '0;
      ramp_left_r <= '0;
      phase_r     <= '0;
      pending_r   <= 1'b1;
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tgt_gain_r  <= tgt_gain_nxt;
      tgt_fb1_r   <= tgt_fb1_nxt;
      tgt_fb2_r   <= tgt_fb2_nxt;
      ramp_log2_r <= ramp_log2_nxt;
      hist1_r     <= hist1_nxt;
      hist2_r     <= hist2_nxt;
      cur_gain_r  <= cur_gain_nxt;
      cur_fb1_r   <= cur_fb1_nxt;
      cur_fb2_r   <= cur_fb2_nxt;
      stp_gain_r  <= stp_gain_nxt;
      stp_fb1_r   <= stp_fb1_nxt;
      stp_fb2_r   <= stp_fb2_nxt;
      ramp_left_r <= ramp_left_nxt;
      phase_r     <= phase_nxt;
      pending_r   <= pending_nxt;
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // an input beat starts the program at its first step
  a_beat_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> busy_r && step_r == '0)
    else $error("program did not start on input beat");

  // a result appears only from the write-back step
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r && ctl.finish))
    else $error("result raised outside write-back step");

  // ramp counter stays within the longest ramp
  a_ramp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ramp_left_r <= (rbpf_pkg::RAMP_W)'(rbpf_pkg::RAMP_MAX))
    else $error("ramp counter out of range");

  // phase counts modulo three
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3)
    else $error("phase counter out of range");

endmodule

// File: tb/sv/rbpf_filter_checker.sv
// result checker for the resonator band-pass filter: watches beats, predicts samples, compares
module rbpf_filter_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic signed [rbpf_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [rbpf_pkg::SAMPLE_W-1:0] out_sample_out,
  input  logic                                 cfg_we,
  input  logic [rbpf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rbpf_pkg::CFG_W-1:0]           cfg_data,
  output int                                   fail_count,
  output int                                   results_due,
  output int                                   results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W    = rbpf_pkg::SAMPLE_W;
  localparam int COEF_W      = rbpf_pkg::COEF_W;
  localparam int GAIN_W      = rbpf_pkg::GAIN_W;
  localparam int LOG_W       = rbpf_pkg::LOG_W;
  localparam int STATE_WIDTH = rbpf_pkg::STATE_WIDTH;
  localparam int RAMP_W      = rbpf_pkg::RAMP_W;
  localparam int FRAC_SHIFT  = rbpf_pkg::FRAC_SHIFT;
  localparam int OUT_SHIFT   = rbpf_pkg::OUT_SHIFT;
  localparam int OUT_HALF    = rbpf_pkg::OUT_HALF;

  // register copies
  logic [GAIN_W-1:0]              tgt_gain;
  logic signed [COEF_W-1:0]       tgt_fb1;
  logic signed [COEF_W-1:0]       tgt_fb2;
  logic [LOG_W-1:0]               ramp_shift;

  // filter history and coefficient ramp
  logic signed [STATE_WIDTH-1:0]  hist_one;
  logic signed [STATE_WIDTH-1:0]  hist_two;
  logic signed [COEF_W-1:0]       cur_gain;
  logic signed [COEF_W-1:0]       cur_fb1;
  logic signed [COEF_W-1:0]       cur_fb2;
  logic signed [COEF_W-1:0]       step_gain;
  logic signed [COEF_W-1:0]       step_fb1;
  logic signed [COEF_W-1:0]       step_fb2;
  logic [RAMP_W-1:0]              ramp_left;
  logic [1:0]                     sample_phase;
  logic                           ramp_arm_due;

  logic signed [SAMPLE_W-1:0]     expected_sample_q[$];
  logic signed [SAMPLE_W-1:0]     want;

  // saturate to a signed width
  function automatic longint clip(input longint v, input int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // coefficient times state, back to state units, round half up
  function automatic longint mul_q22(input logic signed [COEF_W-1:0] c, input longint v);
    logic signed [95:0] a;
    logic signed [95:0] b;
    logic signed [95:0] p;
    a = 96'(c);
    b = 96'(v);
    p = (a * b + (96'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
    return longint'(p[63:0]);
  endfunction

  // one sample through the resonator, moving history and the coefficient ramp on
  function automatic logic signed [SAMPLE_W-1:0] filter_sample(
    input logic signed [SAMPLE_W-1:0] x
  );
    longint w;
    longint v;
    if (ramp_arm_due) begin
      step_gain = COEF_W'(clip((longint'(tgt_gain) - longint'(cur_gain)) >>> ramp_shift,
                               COEF_W));
      step_fb1  = COEF_W'(clip((longint'(tgt_fb1) - longint'(cur_fb1)) >>> ramp_shift,
                               COEF_W));
      step_fb2  = COEF_W'(clip((longint'(tgt_fb2) - longint'(cur_fb2)) >>> ramp_shift,
                               COEF_W));
      ramp_left    = RAMP_W'(1) << ramp_shift;
      sample_phase = '0;
      ramp_arm_due = 1'b0;
    end

    w = (longint'(x) <<< OUT_SHIFT) + mul_q22(cur_fb1, longint'(hist_one))
        + mul_q22(cur_fb2, longint'(hist_two));
    w = clip(w, STATE_WIDTH);
    v = mul_q22(cur_gain, w - longint'(hist_two));
    hist_two = hist_one;
    hist_one = w[STATE_WIDTH-1:0];

    // coefficients step once every third sample, the last step lands on the targets
    sample_phase = sample_phase + 2'd1;
    if (sample_phase == 2'd3) begin
      sample_phase = '0;
      if (ramp_left != '0) begin
        if (ramp_left == RAMP_W'(1)) begin
          cur_gain = {1'b0, tgt_gain};
          cur_fb1  = tgt_fb1;
          cur_fb2  = tgt_fb2;
        end else begin
          cur_gain = COEF_W'(clip(longint'(cur_gain) + longint'(step_gain), COEF_W));
          cur_fb1  = COEF_W'(clip(longint'(cur_fb1) + longint'(step_fb1), COEF_W));
          cur_fb2  = COEF_W'(clip(longint'(cur_fb2) + longint'(step_fb2), COEF_W));
        end
        ramp_left = ramp_left - 1'b1;
      end
    end
    return SAMPLE_W'(clip((v + OUT_HALF) >>> OUT_SHIFT, SAMPLE_W));
  endfunction

  task automatic report_mismatch(input string line);
    $display("[%0t] mismatch: %s", $realtime, line);
    fail_count++;
  endtask

  // follow register writes and beats on both channels
  always @(posedge clk) begin
    if (!rst_n) begin
      tgt_gain     = '0;
      tgt_fb1      = '0;
      tgt_fb2      = '0;
      ramp_shift   = LOG_W'(rbpf_pkg::RAMP_LOG2_RST);
      hist_one     = '0;
      hist_two     = '0;
      cur_gain     = '0;
      cur_fb1      = '0;
      cur_fb2      = '0;
      step_gain    = '0;
      step_fb1     = '0;
      step_fb2     = '0;
      ramp_left    = '0;
      sample_phase = '0;
      ramp_arm_due = 1'b1;
      expected_sample_q.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      // target writes arm a ramp, the ramp length only waits for the next arming
      if (cfg_we) begin
        case (cfg_index)
          rbpf_pkg::REG_TARGET_GAIN: begin
            tgt_gain     = cfg_data[GAIN_W-1:0];
            ramp_arm_due = 1'b1;
          end
          rbpf_pkg::REG_TARGET_FB1: begin
            tgt_fb1      = cfg_data[COEF_W-1:0];
            ramp_arm_due = 1'b1;
          end
          rbpf_pkg::REG_TARGET_FB2: begin
            tgt_fb2      = cfg_data[COEF_W-1:0];
            ramp_arm_due = 1'b1;
          end
          rbpf_pkg::REG_RAMP_LOG2: begin
            ramp_shift = cfg_data[LOG_W-1:0];
          end
          default: begin
          end
        endcase
      end

      if (in_valid && !in_stall) begin
        expected_sample_q.push_back(filter_sample(in_sample_in));
      end

      // each output beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_sample_q.size() == 0) begin
          report_mismatch($sformatf("sample_out %0d with no input beat waiting",
                                    out_sample_out));
        end else begin
          want = expected_sample_q.pop_front();
          results_seen++;
          if (out_sample_out !== want) begin
            report_mismatch($sformatf("sample_out of beat %0d is %0d, predicted %0d",
                                      results_seen, out_sample_out, want));
          end
        end
      end
    end
    results_due = expected_sample_q.size();
  end

endmodule

// File: tb/sv/tb_resonator_bandpass_filter_unit.sv
// testbench top for the resonator band-pass filter: stimulus, flow control and verdict
module tb_resonator_bandpass_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W      = rbpf_pkg::SAMPLE_W;
  localparam int CFG_IDX_W     = rbpf_pkg::CFG_IDX_W;
  localparam int CFG_W         = rbpf_pkg::CFG_W;
  localparam int GAIN_W        = rbpf_pkg::GAIN_W;

  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_SAMPLES = 50;
  localparam int IDLE_PCT      = 31;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 4000;

  logic                       clk          = 1'b0;
  logic                       rst_n        = 1'b0;
  logic                       in_valid     = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic                       out_valid;
  logic                       out_stall    = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index    = '0;
  logic [CFG_W-1:0]           cfg_data     = '0;

  int fail_count;
  int results_due;
  int results_seen;
  bit gaps_on    = 1'b1;
  bit hold_req   = 1'b0;
  int hold_left  = 0;
  int quiet      = 0;
  int n_samples  = 0;
  int n_writes   = 0;

  resonator_bandpass_filter_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  rbpf_filter_checker filter_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .results_due    (results_due),
    .results_seen   (results_seen)
  );

  // 8 ns clock
  initial begin
    forever #4 clk = ~clk;
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= gaps_on && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // watchdog on cycles without any beat or write
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // offer one sample beat, with random gaps before it, and wait for it to be taken
  task automatic put_sample(input logic signed [SAMPLE_W-1:0] s);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    n_samples++;
  endtask

  task automatic write_reg(input rbpf_pkg::cfg_reg_t idx, input logic [CFG_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    n_writes++;
  endtask

  // stop offering and wait until every predicted sample has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // mostly full-range samples, some full scale, some near zero
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1:       return SAMPLE_W'(int'($urandom_range(0, 128)) - 64);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int k;
    int gain;
    int mag2;
    int lim;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // first samples arm a ramp towards the reset targets
    put_sample(16'sh7FFF);
    put_sample(16'sh8000);
    drain();

    // single-step ramp, unity gain, resonant poles; bits above each register dropped
    write_reg(rbpf_pkg::REG_RAMP_LOG2, 24'hFFFFF8);
    write_reg(rbpf_pkg::REG_TARGET_GAIN, 24'hC00000);
    write_reg(rbpf_pkg::REG_TARGET_FB1, 24'd7969178);
    write_reg(rbpf_pkg::REG_TARGET_FB2, CFG_W'(-3984589));
    put_sample(16'sh7FFF);
    repeat (4) put_sample(16'sh0000);
    put_sample(16'sh8000);
    put_sample(16'sh7FFF);
    put_sample(-16'sd1);
    put_sample(16'sd1);
    drain();

    // ramp length alone does not arm; then full-scale targets drive saturation
    write_reg(rbpf_pkg::REG_RAMP_LOG2, 24'd1);
    write_reg(rbpf_pkg::REG_TARGET_GAIN, 24'h7FFFFF);
    write_reg(rbpf_pkg::REG_TARGET_FB1, 24'h7FFFFF);
    write_reg(rbpf_pkg::REG_TARGET_FB2, 24'h800000);
    repeat (4) put_sample(16'sh7FFF);
    repeat (4) put_sample(16'sh8000);
    drain();

    // longest ramp, interrupted by a fresh write that re-arms mid-way
    write_reg(rbpf_pkg::REG_RAMP_LOG2, 24'd7);
    write_reg(rbpf_pkg::REG_TARGET_GAIN, 24'd0);
    repeat (3) put_sample(rand_sample());
    drain();
    write_reg(rbpf_pkg::REG_TARGET_FB2, 24'd0);
    repeat (3) put_sample(rand_sample());

    // random settings, each followed by a run of random samples
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      gaps_on = (p != 3);

      // shortest and longest ramps first, then random lengths with junk upper bits
      if (p < 2 || $urandom_range(0, 1)) begin
        k = (p == 0) ? 0 : (p == 1) ? 7 : int'($urandom_range(0, 7));
        write_reg(rbpf_pkg::REG_RAMP_LOG2, (CFG_W'($urandom) & ~CFG_W'(7)) | CFG_W'(k));
      end

      if (p == 7) begin
        write_reg(rbpf_pkg::REG_TARGET_GAIN, 24'hFFFFFF);
        write_reg(rbpf_pkg::REG_TARGET_FB1, 24'h800000);
        write_reg(rbpf_pkg::REG_TARGET_FB2, 24'h7FFFFF);
      end else begin
        if ($urandom_range(0, 2) != 0) begin
          case ($urandom_range(0, 3))
            0:       gain = $urandom_range(0, 1 << 19);
            1:       gain = $urandom_range(0, (1 << GAIN_W) - 1);
            default: gain = $urandom_range(0, 1 << 22);
          endcase
          write_reg(rbpf_pkg::REG_TARGET_GAIN, {1'($urandom), GAIN_W'(gain)});
        end
        // mostly a stable pole pair, sometimes raw coefficients
        if ($urandom_range(0, 3) != 0) begin
          mag2 = $urandom_range(2097152, 4190000);
          lim  = 4194304 + mag2 - 8192;
          write_reg(rbpf_pkg::REG_TARGET_FB2, CFG_W'(-mag2));
          write_reg(rbpf_pkg::REG_TARGET_FB1,
                    CFG_W'(int'($urandom_range(0, 2 * lim)) - lim));
        end else begin
          if ($urandom_range(0, 1)) write_reg(rbpf_pkg::REG_TARGET_FB1, CFG_W'($urandom));
          if ($urandom_range(0, 1)) write_reg(rbpf_pkg::REG_TARGET_FB2, CFG_W'($urandom));
        end
      end

      for (int i = 0; i < PHASE_SAMPLES; i++) begin
        if (p == 5 && i == 10) hold_req = 1'b1;
        put_sample(rand_sample());
      end
    end

    drain();
    repeat (16) @(negedge clk);

    $display("run covered %0d samples and %0d register writes, ramps of 1 to 128 steps",
             n_samples, n_writes);
    $display("%0d output beats checked, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: resonator_bandpass_filter_unit.f
sv/rbpf_pkg.sv
sv/resonator_bandpass_filter_unit.sv
tb/sv/rbpf_filter_checker.sv
tb/sv/tb_resonator_bandpass_filter_unit.sv
